// ===== rtl/spq_pkg.sv =====
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the stable priority queue
// Sizes, entry word layout, operation and status codes.
// ----------------------------------------------------------------------------
package spq_pkg;

  localparam int DEPTH      = 16;
  localparam int PRI_WIDTH  = 8;
  localparam int DATA_WIDTH = 16;
  localparam int CNT_WIDTH  = $clog2(DEPTH + 1);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef struct packed {
    logic [PRI_WIDTH-1:0]  pri;
    logic [DATA_WIDTH-1:0] data;
  } entry_t;

  // Broadcast to every cell of the row in the cycle a word is taken
  typedef struct packed {
    logic   ins;
    logic   rem;
    entry_t word;
  } cmd_t;

endpackage

// ===== rtl/spq_cell.sv =====
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted row
// Holds one entry; on insert keeps, takes the new word or takes the left
// neighbour's entry; on remove takes the right neighbour's entry.
// ----------------------------------------------------------------------------
module spq_cell (
  input  logic           clk,
  input  logic           occupied,
  input  spq_pkg::cmd_t  cmd,
  input  logic           left_ge,
  input  spq_pkg::entry_t left_entry,
  input  spq_pkg::entry_t right_entry,
  output logic           ge,
  output spq_pkg::entry_t entry
);

  spq_pkg::entry_t entry_next;

  // Entry stays ahead of the new word: equal priorities keep arrival order
  assign ge = occupied && (entry.pri >= cmd.word.pri);

  always_comb begin
    entry_next = entry;
    priority if (cmd.ins) begin
      if (!ge) begin
        entry_next = left_ge ? cmd.word : left_entry;
      end
    end else if (cmd.rem) begin
      entry_next = right_entry;
    end else begin
      entry_next = entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/stable_priority_queue_top.sv =====
// ----------------------------------------------------------------------------
// stable_priority_queue_top: sorted-row priority queue
// The result strobe done is high the cycle after start.
// Throughput: one word per cycle, busy stays low; the row of cells compares
// and shifts in parallel.
// Reset: synchronous; clears the entry count and the strobe, queue is empty.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
module stable_priority_queue_top (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [spq_pkg::PRI_WIDTH-1:0]  priority_req,
  input  logic [spq_pkg::DATA_WIDTH-1:0] payload,
  output logic                           done,
  output logic [1:0]                     status,
  output logic                           item_valid,
  output logic [spq_pkg::PRI_WIDTH-1:0]  out_priority,
  output logic [spq_pkg::DATA_WIDTH-1:0] out_payload,
  output logic [spq_pkg::CNT_WIDTH-1:0]  fill_level
);

  logic                          accept;
  logic                          is_remove;
  logic                          full;
  logic                          empty;
  logic [spq_pkg::CNT_WIDTH-1:0] count;
  logic [spq_pkg::CNT_WIDTH-1:0] count_next;
  spq_pkg::cmd_t                 cmd;
  spq_pkg::entry_t               entries [spq_pkg::DEPTH];
  logic [spq_pkg::DEPTH-1:0]     ge;

  assign busy      = 1'b0;
  assign accept    = start && !busy;
  assign is_remove = (opcode == spq_pkg::OP_REMOVE);
  assign full      = (count == spq_pkg::CNT_WIDTH'(spq_pkg::DEPTH));
  assign empty     = (count == '0);

  always_comb begin
    cmd.ins       = accept && !is_remove && !full;
    cmd.rem       = accept && is_remove && !empty;
    cmd.word.pri  = priority_req;
    cmd.word.data = payload;
  end

  always_comb begin
    count_next = count;
    priority if (cmd.ins) begin
      count_next = count + 1'b1;
    end else if (cmd.rem) begin
      count_next = count - 1'b1;
    end else begin
      count_next = count;
    end
  end

  for (genvar i = 0; i < spq_pkg::DEPTH; i++) begin : g_cell
    logic            occ;
    logic            lge;
    spq_pkg::entry_t lent;
    spq_pkg::entry_t rent;

    assign occ = (spq_pkg::CNT_WIDTH'(i) < count);

    if (i == 0) begin : g_head
      // virtual entry ahead of the head always outranks the new word
      assign lge  = 1'b1;
      assign lent = cmd.word;
    end else begin : g_body
      assign lge  = ge[i-1];
      assign lent = entries[i-1];
    end

    if (i == spq_pkg::DEPTH - 1) begin : g_tail
      assign rent = entries[i];
    end else begin : g_inner
      assign rent = entries[i+1];
    end

    spq_cell u_cell (
      .clk        (clk),
      .occupied   (occ),
      .cmd        (cmd),
      .left_ge    (lge),
      .left_entry (lent),
      .right_entry(rent),
      .ge         (ge[i]),
      .entry      (entries[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
    end
  end

  // Result word; no reset needed on the payload
  always_ff @(posedge clk) begin
    if (accept) begin
      fill_level   <= count_next;
      item_valid   <= cmd.rem;
      out_priority <= cmd.rem ? entries[0].pri : '0;
      out_payload  <= cmd.rem ? entries[0].data : '0;
      if (!is_remove && full) begin
        status <= spq_pkg::ST_FULL;
      end else if (is_remove && empty) begin
        status <= spq_pkg::ST_EMPTY;
      end else begin
        status <= spq_pkg::ST_DONE;
      end
    end
  end

  a_fill_matches_count: assert property (@(posedge clk) disable iff (rst)
    done |-> fill_level == count)
    else $error("reported fill level differs from held count");

  a_valid_only_when_done: assert property (@(posedge clk) disable iff (rst)
    (done && item_valid) |-> status == spq_pkg::ST_DONE)
    else $error("removed entry flagged with failure status");

  a_empty_remove: assert property (@(posedge clk) disable iff (rst)
    (accept && is_remove && empty) |=> (done && !item_valid
                                        && status == spq_pkg::ST_EMPTY))
    else $error("remove from empty queue not reported");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= spq_pkg::CNT_WIDTH'(spq_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_head_sorted: assert property (@(posedge clk) disable iff (rst)
    (count >= spq_pkg::CNT_WIDTH'(2)) |-> entries[0].pri >= entries[1].pri)
    else $error("head entries out of priority order");

endmodule

// ===== test/stable_priority_queue_top_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stable_priority_queue_top_tb: self-checking bench for the sorted priority queue
// Drives insert and remove words through the start/busy handshake with random
// gaps. A scoreboard keeps its own sorted row and predicts each strobed result:
// the removed entry, full and empty rejections, and the fill level.
// ----------------------------------------------------------------------------
module stable_priority_queue_top_tb;

  typedef struct {
    logic [1:0]                     status;
    logic                           valid;
    logic [spq_pkg::PRI_WIDTH-1:0]  pri;
    logic [spq_pkg::DATA_WIDTH-1:0] data;
    logic [spq_pkg::CNT_WIDTH-1:0]  fill;
  } queue_result_t;

  class queue_scoreboard;
    spq_pkg::entry_t sorted_row[spq_pkg::DEPTH];
    int              row_count;
    queue_result_t   awaited[$];
    int unsigned     failures;
    int unsigned     inserts_taken;
    int unsigned     removes_taken;
    int unsigned     full_rejects;
    int unsigned     empty_rejects;
    int unsigned     peak_fill;

    function new();
      row_count     = 0;
      failures      = 0;
      inserts_taken = 0;
      removes_taken = 0;
      full_rejects  = 0;
      empty_rejects = 0;
      peak_fill     = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Work out the result of one accepted word and queue it
    function void note_word(spq_pkg::op_t op, logic [spq_pkg::PRI_WIDTH-1:0] pri,
                            logic [spq_pkg::DATA_WIDTH-1:0] data);
      queue_result_t r;
      int            slot;
      int            i;
      r.status = spq_pkg::ST_DONE;
      r.valid  = 1'b0;
      r.pri    = '0;
      r.data   = '0;
      if (op == spq_pkg::OP_INSERT) begin
        inserts_taken++;
        if (row_count >= spq_pkg::DEPTH) begin
          r.status = spq_pkg::ST_FULL;
          full_rejects++;
        end else begin
          // go in ahead of the first strictly lower priority, so ties keep order
          slot = 0;
          while (slot < row_count && sorted_row[slot].pri >= pri) slot++;
          for (i = row_count; i > slot; i--) sorted_row[i] = sorted_row[i-1];
          sorted_row[slot].pri  = pri;
          sorted_row[slot].data = data;
          row_count++;
        end
      end else begin
        removes_taken++;
        if (row_count == 0) begin
          r.status = spq_pkg::ST_EMPTY;
          empty_rejects++;
        end else begin
          r.valid = 1'b1;
          r.pri   = sorted_row[0].pri;
          r.data  = sorted_row[0].data;
          for (i = 1; i < row_count; i++) sorted_row[i-1] = sorted_row[i];
          row_count--;
        end
      end
      r.fill = row_count[spq_pkg::CNT_WIDTH-1:0];
      if (row_count > peak_fill) peak_fill = row_count;
      awaited.push_back(r);
    endfunction

    function void check_result(logic [1:0] got_status, logic got_valid,
                               logic [spq_pkg::PRI_WIDTH-1:0] got_pri,
                               logic [spq_pkg::DATA_WIDTH-1:0] got_data,
                               logic [spq_pkg::CNT_WIDTH-1:0] got_fill);
      queue_result_t want;
      if (awaited.size() == 0) begin
        $error("result strobed with no word outstanding (status %0d)", got_status);
        failures++;
        return;
      end
      want = awaited.pop_front();
      if (got_status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got_status);
        failures++;
      end
      if (got_valid !== want.valid) begin
        $error("item_valid: expected %0d, actual %0d", want.valid, got_valid);
        failures++;
      end
      if (got_pri !== want.pri) begin
        $error("out_priority: expected 0x%0h, actual 0x%0h", want.pri, got_pri);
        failures++;
      end
      if (got_data !== want.data) begin
        $error("out_payload: expected 0x%0h, actual 0x%0h", want.data, got_data);
        failures++;
      end
      if (got_fill !== want.fill) begin
        $error("fill_level: expected %0d, actual %0d", want.fill, got_fill);
        failures++;
      end
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           start;
  logic                           busy;
  logic                           opcode;
  logic [spq_pkg::PRI_WIDTH-1:0]  priority_req;
  logic [spq_pkg::DATA_WIDTH-1:0] payload;
  logic                           done;
  logic [1:0]                     status;
  logic                           item_valid;
  logic [spq_pkg::PRI_WIDTH-1:0]  out_priority;
  logic [spq_pkg::DATA_WIDTH-1:0] out_payload;
  logic [spq_pkg::CNT_WIDTH-1:0]  fill_level;

  queue_scoreboard sb;

  stable_priority_queue_top DUT (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .opcode       (opcode),
    .priority_req (priority_req),
    .payload      (payload),
    .done         (done),
    .status       (status),
    .item_valid   (item_valid),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .fill_level   (fill_level)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Values read here are the ones held through the cycle this edge ends
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_word(spq_pkg::op_t'(opcode), priority_req, payload);
      if (done) sb.check_result(status, item_valid, out_priority, out_payload, fill_level);
    end
  end

  // Present a word and hold it until the edge that takes it
  task automatic send_word(spq_pkg::op_t op, logic [spq_pkg::PRI_WIDTH-1:0] pri,
                           logic [spq_pkg::DATA_WIDTH-1:0] data);
    start        <= 1'b1;
    opcode       <= op;
    priority_req <= pri;
    payload      <= data;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_sender(int cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  // Hold off until every outstanding result has been strobed
  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic int pick_gap(bit no_idle);
    int r;
    if (no_idle) return 0;
    r = $urandom_range(99);
    if (r < 65) return 0;
    if (r < 94) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [spq_pkg::PRI_WIDTH-1:0] pick_priority(int mode);
    case (mode)
      0: return spq_pkg::PRI_WIDTH'($urandom_range(255));
      // few distinct values, so ties are common
      1: begin
        case ($urandom_range(3))
          0: return 8'h00;
          1: return 8'hff;
          2: return 8'h80;
          default: return 8'h7f;
        endcase
      end
      default: return spq_pkg::PRI_WIDTH'(8'h40 + $urandom_range(3));
    endcase
  endfunction

  initial begin
    int phase;
    int n;
    int ins_pct;
    int pri_mode;
    bit no_idle;
    spq_pkg::op_t op;

    sb           = new();
    rst          = 1'b1;
    start        = 1'b0;
    opcode       = spq_pkg::OP_INSERT;
    priority_req = '0;
    payload      = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty remove, field extremes, ties, drain to empty again
    send_word(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_word(spq_pkg::OP_INSERT, 8'h00, 16'h0000);
    send_word(spq_pkg::OP_INSERT, 8'hff, 16'hffff);
    send_word(spq_pkg::OP_INSERT, 8'h80, 16'haaaa);
    send_word(spq_pkg::OP_INSERT, 8'h80, 16'h5555);
    pause_sender(2);
    send_word(spq_pkg::OP_INSERT, 8'h80, 16'h1234);
    send_word(spq_pkg::OP_INSERT, 8'h00, 16'hffff);
    send_word(spq_pkg::OP_INSERT, 8'hff, 16'h0001);
    send_word(spq_pkg::OP_REMOVE, 8'hff, 16'hffff);
    send_word(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    pause_sender(1);
    send_word(spq_pkg::OP_REMOVE, 8'h55, 16'h5a5a);
    send_word(spq_pkg::OP_REMOVE, 8'haa, 16'ha5a5);
    send_word(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_word(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_word(spq_pkg::OP_REMOVE, 8'h00, 16'h0000);
    send_word(spq_pkg::OP_REMOVE, 8'hff, 16'hffff);
    wait_drained();

    // Random phases with varying insert bias, priority spread and idling
    for (phase = 0; phase < 14; phase++) begin
      case (phase % 5)
        0: ins_pct = 90;
        1: ins_pct = 50;
        2: ins_pct = 20;
        3: ins_pct = 75;
        default: ins_pct = 35;
      endcase
      pri_mode = $urandom_range(2);
      no_idle  = ($urandom_range(3) == 0);
      for (n = 0; n < 100; n++) begin
        op = ($urandom_range(99) < ins_pct) ? spq_pkg::OP_INSERT : spq_pkg::OP_REMOVE;
        send_word(op, pick_priority(pri_mode),
                  spq_pkg::DATA_WIDTH'($urandom_range(16'hffff)));
        pause_sender(pick_gap(no_idle));
      end
      if (phase == 0 || $urandom_range(2) == 0) wait_drained();
    end

    wait_drained();
    $display("Covered %0d inserts (%0d rejected full) and %0d removes (%0d found empty).",
             sb.inserts_taken, sb.full_rejects, sb.removes_taken, sb.empty_rejects);
    $display("Highest fill level reached: %0d of %0d.", sb.peak_fill, spq_pkg::DEPTH);
    if (sb.failures == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin
    #(200000 * 12);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
